/* rtl/magic_length_deframer_assert.svh */
// Assertion macros shared by the deframer RTL.
// Each macro expects signals named clock and reset in the including module.
`ifndef MAGIC_LENGTH_DEFRAMER_ASSERT_SVH
`define MAGIC_LENGTH_DEFRAMER_ASSERT_SVH

// Same-cycle implication.
`define MLD_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define MLD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/mld_pkg.sv */
// Shared types and constants for the magic/length deframer.
// No dependencies.
`timescale 1ns / 1ps

package mld_pkg;

   typedef logic [1:0] kind_type;

   localparam kind_type KIND_PAYLOAD  = 2'd0;
   localparam kind_type KIND_EMPTY    = 2'd1;
   localparam kind_type KIND_MISMATCH = 2'd2;

   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;

   // one result word as it travels from front to back
   typedef struct packed {
      kind_type   kind;
      logic [7:0] payload_byte;
      logic       last;
   } result_type;

   // queue status seen by front and back
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

/* rtl/mld_front.sv */
// Front end of the deframer: accepts stream bytes, tracks header/payload phase.
// Depends on mld_pkg and magic_length_deframer_assert.svh.
`timescale 1ns / 1ps
`include "magic_length_deframer_assert.svh"

module mld_front
   import mld_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic [31:0] cfg_magic_word,
   input  qstat_type   qstat,
   output logic        push,
   output result_type  push_word
);

   localparam logic [2:0] HDR_LAST = 3'd7;

   logic        in_payload_ff, in_payload_in;
   logic [2:0]  header_count_ff, header_count_in;
   logic [55:0] header_shift_ff, header_shift_in;
   logic [31:0] bytes_remaining_ff, bytes_remaining_in;
   logic        accept;
   logic        last_byte;
   logic [31:0] hdr_magic;
   logic [31:0] hdr_len;

   assign req_ready = !qstat.full;
   assign accept    = req_valid && req_ready;
   assign last_byte = (bytes_remaining_ff <= 32'd1);
   assign hdr_magic = header_shift_ff[55:24];
   assign hdr_len   = {header_shift_ff[23:0], req_data_byte};

   always_comb begin
      in_payload_in      = in_payload_ff;
      header_count_in    = header_count_ff;
      header_shift_in    = header_shift_ff;
      bytes_remaining_in = bytes_remaining_ff;
      push               = 1'b0;
      push_word          = '0;
      if (accept) begin
         if (in_payload_ff) begin
            push                   = 1'b1;
            push_word.kind         = KIND_PAYLOAD;
            push_word.payload_byte = req_data_byte;
            push_word.last         = last_byte;
            if (last_byte) begin
               bytes_remaining_in = '0;
               in_payload_in      = 1'b0;
            end else begin
               bytes_remaining_in = bytes_remaining_ff - 32'd1;
            end
         end else if (header_count_ff != HDR_LAST) begin
            header_shift_in = {header_shift_ff[47:0], req_data_byte};
            header_count_in = header_count_ff + 3'd1;
         end else begin
            header_count_in = '0;
            header_shift_in = '0;
            if (hdr_magic != cfg_magic_word) begin
               push           = 1'b1;
               push_word.kind = KIND_MISMATCH;
            end else if (hdr_len == 32'd0) begin
               push           = 1'b1;
               push_word.kind = KIND_EMPTY;
               push_word.last = 1'b1;
            end else begin
               in_payload_in      = 1'b1;
               bytes_remaining_in = hdr_len;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_payload_ff      <= 1'b0;
         header_count_ff    <= '0;
         header_shift_ff    <= '0;
         bytes_remaining_ff <= '0;
      end else begin
         in_payload_ff      <= in_payload_in;
         header_count_ff    <= header_count_in;
         header_shift_ff    <= header_shift_in;
         bytes_remaining_ff <= bytes_remaining_in;
      end
   end

   `MLD_ASSERT_NOW(a_payload_no_header, in_payload_ff, header_count_ff == 3'd0, "header count live in payload phase")
   `MLD_ASSERT_NOW(a_payload_nonzero, in_payload_ff, bytes_remaining_ff != 32'd0, "payload phase with nothing left")
   `MLD_ASSERT_NEXT(a_last_leaves, accept && in_payload_ff && last_byte, !in_payload_ff, "payload phase held past last byte")

endmodule

/* rtl/mld_queue.sv */
// Short result queue between front and back of the deframer.
// Depends on mld_pkg and magic_length_deframer_assert.svh.
`timescale 1ns / 1ps
`include "magic_length_deframer_assert.svh"

module mld_queue
   import mld_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_word,
   input  logic       pop,
   output result_type head_word,
   output qstat_type  qstat
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   result_type      mem [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   assign qstat.full  = (count_ff == CW'(DEPTH));
   assign qstat.empty = (count_ff == '0);
   assign head_word   = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `MLD_ASSERT_NOW(a_no_overflow, push, !qstat.full, "push into full queue")
   `MLD_ASSERT_NOW(a_no_underflow, pop, !qstat.empty, "pop from empty queue")
   `MLD_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CW'(DEPTH), "queue count past depth")

endmodule

/* rtl/mld_back.sv */
// Back end of the deframer: drains the queue into the registered result port.
// Depends on mld_pkg.
`timescale 1ns / 1ps

module mld_back
   import mld_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  qstat_type  qstat,
   input  result_type head_word,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output kind_type   rsp_out_kind,
   output logic [7:0] rsp_payload_byte,
   output logic       rsp_last_in_message
);

   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_word_ff;

   // load whenever the output slot is free or being emptied this cycle
   assign pop          = !qstat.empty && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid_in = pop || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_word_ff <= head_word;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_out_kind        = rsp_word_ff.kind;
   assign rsp_payload_byte    = rsp_word_ff.payload_byte;
   assign rsp_last_in_message = rsp_word_ff.last;

endmodule

/* rtl/magic_length_deframer.sv */
// Magic/length deframer. Feed the received stream one byte per word on req_;
// each frame is an 8-byte header (32-bit big-endian magic, then 32-bit
// big-endian payload length) followed by the payload. Payload bytes come out
// on rsp_ one per word with rsp_last_in_message set on the final one; a
// zero-length header gives one empty-message word (last set); a header whose
// magic differs from the magic_word register gives one mismatch word, and the
// block resumes hunting for the next header right after it. The block takes
// one byte per clock cycle while its queue is not full; each result word is
// written into the queue and then loaded into the output register that drives
// rsp_. Between the byte tracker and the output register sits a queue of
// QUEUE_DEPTH words, and req_ready drops only when that queue is full, so a
// stalled consumer holds the input back only after the queue fills. Write
// magic_word (byte address 0) over the APB-style csr_ port while the stream
// is idle; it reads back as written.
`timescale 1ns / 1ps

module magic_length_deframer
   import mld_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   // input stream
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [7:0]                req_data_byte,
   // result stream
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [1:0]                rsp_out_kind,
   output logic [7:0]                rsp_payload_byte,
   output logic                      rsp_last_in_message,
   // configuration port
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready
);

   // register index of magic_word, taken from the word-aligned address bits
   localparam logic REG_MAGIC_WORD = 1'b0;

   logic [31:0] magic_word_ff;
   logic        csr_write;
   logic        csr_hit;
   qstat_type   qstat;
   logic        push;
   logic        pop;
   result_type  push_word;
   result_type  head_word;
   kind_type    out_kind;

   // Configuration: zero-wait access, write on the access phase.
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[CSR_ADDR_WIDTH-1:2] == REG_MAGIC_WORD);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = csr_hit ? magic_word_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_word_ff <= '0;
      end else if (csr_write && csr_hit) begin
         magic_word_ff <= csr_pwdata;
      end
   end

   // Front: classify each byte, push at most one result word.
   mld_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .cfg_magic_word (magic_word_ff),
      .qstat          (qstat),
      .push           (push),
      .push_word      (push_word)
   );

   // Queue: decouple the byte tracker from consumer stalls.
   mld_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .pop       (pop),
      .head_word (head_word),
      .qstat     (qstat)
   );

   // Back: hold each result word in the output register until taken.
   mld_back u_back (
      .clock               (clock),
      .reset               (reset),
      .qstat               (qstat),
      .head_word           (head_word),
      .pop                 (pop),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_out_kind        (out_kind),
      .rsp_payload_byte    (rsp_payload_byte),
      .rsp_last_in_message (rsp_last_in_message)
   );

   assign rsp_out_kind = out_kind;

endmodule

/* tb/tb.sv */
// Self-checking testbench for magic_length_deframer: byte stream in, frame words out.
// Depends on mld_pkg and the magic_length_deframer RTL; needs nothing else.
`timescale 1ns / 1ps

module tb;
   import mld_pkg::*;

   localparam int CLK_PERIOD      = 10;
   localparam int RESET_CYCLES    = 5;
   localparam int DIRECTED_ROWS   = 26;
   localparam int PHASES          = 6;
   localparam int ITEMS_PER_PHASE = 300;
   // a result passes through the queue and the output register; allow for the full queue as well
   localparam int SETTLE_CYCLES   = 12;
   localparam int TAIL_CYCLES     = 20;
   localparam int STALL_LIMIT     = 1000;

   // register map: index i sits at byte address 4*i
   localparam int REG_MAGIC_WORD = 0;
   localparam int REG_UNMAPPED   = 1;
   localparam logic [CSR_ADDR_WIDTH-1:0] ADDR_MAGIC_WORD = CSR_ADDR_WIDTH'(REG_MAGIC_WORD * 4);
   localparam logic [CSR_ADDR_WIDTH-1:0] ADDR_UNMAPPED   = CSR_ADDR_WIDTH'(REG_UNMAPPED * 4);

   // how a stimulus row is checked
   typedef enum logic [1:0] {
      CHK_MODEL,   // whatever the deframer model yields
      CHK_SILENT,  // typed in: no word comes out
      CHK_WORD     // typed in: exactly the word in the row
   } check_mode_type;

   typedef struct packed {
      logic [7:0]     data;
      check_mode_type mode;
      result_type     word;
   } stim_row_type;

   typedef struct packed {
      logic        in_payload;
      logic [2:0]  hdr_count;
      logic [55:0] hdr_shift;
      logic [31:0] remaining;
   } deframe_state_type;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic [7:0]                req_data_byte;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [1:0]                rsp_out_kind;
   logic [7:0]                rsp_payload_byte;
   logic                      rsp_last_in_message;
   logic                      csr_psel;
   logic                      csr_penable;
   logic                      csr_pwrite;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;

   // row currently offered on req_, read back by the monitor at acceptance
   stim_row_type      offered_row;
   stim_row_type      directed_rows [DIRECTED_ROWS];
   stim_row_type      stim_q [$];
   result_type        expected_words [$];

   // generator-side copy of the parser, kept in step with stim_q
   deframe_state_type gen_state;
   logic [31:0]       gen_magic;

   // monitor-side copy of the parser and the magic register
   deframe_state_type live_state;
   logic [31:0]       live_magic;

   logic              idling_enabled;
   int                fail_count;
   int                quiet_cycles;
   int                rsp_stall_left;

   magic_length_deframer u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_data_byte       (req_data_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_out_kind        (rsp_out_kind),
      .rsp_payload_byte    (rsp_payload_byte),
      .rsp_last_in_message (rsp_last_in_message),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .csr_pready          (csr_pready)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Advance the frame parser by one byte; report the word it emits, if any.
   function automatic deframe_state_type deframe_next(input deframe_state_type s,
                                                      input logic [7:0] b,
                                                      input logic [31:0] magic,
                                                      output logic emits,
                                                      output result_type word);
      deframe_state_type n;
      logic [31:0]       hdr_magic;
      logic [31:0]       hdr_len;
      n     = s;
      emits = 1'b0;
      word  = '0;
      if (s.in_payload) begin
         // pass the byte; a count of one or less closes the message
         emits             = 1'b1;
         word.kind         = KIND_PAYLOAD;
         word.payload_byte = b;
         word.last         = (s.remaining <= 32'd1);
         if (word.last) begin
            n.remaining  = '0;
            n.in_payload = 1'b0;
         end else begin
            n.remaining = s.remaining - 32'd1;
         end
      end else if (s.hdr_count < 3'd7) begin
         n.hdr_shift = {s.hdr_shift[47:0], b};
         n.hdr_count = s.hdr_count + 3'd1;
      end else begin
         // eighth header byte: judge magic, then length
         hdr_magic   = s.hdr_shift[55:24];
         hdr_len     = {s.hdr_shift[23:0], b};
         n.hdr_count = '0;
         n.hdr_shift = '0;
         if (hdr_magic != magic) begin
            emits     = 1'b1;
            word.kind = KIND_MISMATCH;
         end else if (hdr_len == 32'd0) begin
            emits     = 1'b1;
            word.kind = KIND_EMPTY;
            word.last = 1'b1;
         end else begin
            n.in_payload = 1'b1;
            n.remaining  = hdr_len;
         end
      end
      return n;
   endfunction

   function automatic stim_row_type stim_row(input logic [7:0] data,
                                             input check_mode_type mode,
                                             input kind_type kind = KIND_PAYLOAD,
                                             input logic [7:0] pbyte = 8'h00,
                                             input logic last = 1'b0);
      stim_row_type r;
      r.data              = data;
      r.mode              = mode;
      r.word.kind         = kind;
      r.word.payload_byte = pbyte;
      r.word.last         = last;
      return r;
   endfunction

   // Queue one row and keep the generator parser in step with it.
   task automatic queue_row(input stim_row_type r);
      logic       emits;
      result_type word;
      gen_state = deframe_next(gen_state, r.data, gen_magic, emits, word);
      stim_q.push_back(r);
   endtask

   task automatic queue_word32(input logic [31:0] w);
      for (int i = 3; i >= 0; i--) begin
         queue_row(stim_row(w[8*i +: 8], CHK_MODEL));
      end
   endtask

   // Build one phase of random traffic: mostly good frames with random content,
   // some bad-magic headers and some loose noise that throws the stream off step.
   task automatic build_phase(input int n_items);
      int          choice;
      int          len;
      int          n_noise;
      logic [31:0] bad_magic;
      while (stim_q.size() < n_items) begin
         if (gen_state.in_payload || gen_state.hdr_count != 3'd0) begin
            // stream is mid-frame: fill with random bytes until back on a header edge
            queue_row(stim_row(8'($urandom), CHK_MODEL));
            continue;
         end
         choice = $urandom_range(0, 99);
         if (choice < 70) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 64) : $urandom_range(0, 8);
            queue_word32(gen_magic);
            queue_word32(32'(len));
            for (int i = 0; i < len; i++) begin
               queue_row(stim_row(8'($urandom), CHK_MODEL));
            end
         end else if (choice < 85) begin
            // flip one bit of the magic, or take any word at all
            if ($urandom_range(0, 1) == 0) begin
               bad_magic = gen_magic ^ (32'h1 << $urandom_range(0, 31));
            end else begin
               bad_magic = $urandom;
            end
            queue_word32(bad_magic);
            queue_word32($urandom);
         end else begin
            n_noise = $urandom_range(1, 7);
            for (int i = 0; i < n_noise; i++) begin
               queue_row(stim_row(8'($urandom), CHK_MODEL));
            end
         end
      end
   endtask

   // Drive every queued row onto req_, one word per handshake. Call at a falling edge.
   task automatic send_stream();
      stim_row_type r;
      while (stim_q.size() != 0) begin
         if (idling_enabled && $urandom_range(0, 7) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clock);
         end
         r = stim_q.pop_front();
         req_valid     <= 1'b1;
         req_data_byte <= r.data;
         offered_row   <= r;
         // hold the word until the edge that takes it
         @(posedge clock);
         while (!req_ready) @(posedge clock);
         @(negedge clock);
      end
      req_valid <= 1'b0;
   endtask

   // Both register tasks leave the bus idle before they return, so calls can follow back to back.
   task automatic csr_write(input logic [CSR_ADDR_WIDTH-1:0] addr,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   task automatic csr_read(input logic [CSR_ADDR_WIDTH-1:0] addr,
                           output logic [CSR_DATA_WIDTH-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= addr;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      data = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   // Wait until every expected word is in, then let the pipeline run dry.
   task automatic wait_idle(input int extra_cycles);
      while (expected_words.size() != 0) @(posedge clock);
      repeat (extra_cycles) @(posedge clock);
      @(negedge clock);
   endtask

   // Consumer side: drop rsp_ready in bursts of random length.
   always @(negedge clock) begin
      if (rsp_stall_left > 0) begin
         rsp_ready      <= 1'b0;
         rsp_stall_left <= rsp_stall_left - 1;
      end else if (idling_enabled && !reset && $urandom_range(0, 9) == 0) begin
         rsp_ready      <= 1'b0;
         rsp_stall_left <= $urandom_range(1, 16) - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Monitor: track register writes, check outgoing words, predict on incoming bytes.
   always @(posedge clock) begin
      logic       emits;
      result_type word;
      result_type got;
      if (!reset) begin
         // out-of-range register indexes are ignored
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             (csr_paddr >> 2) == REG_MAGIC_WORD) begin
            live_magic = csr_pwdata;
         end
         if (rsp_valid && rsp_ready) begin
            got.kind         = rsp_out_kind;
            got.payload_byte = rsp_payload_byte;
            got.last         = rsp_last_in_message;
            if (expected_words.size() == 0) begin
               $display("%0t: unexpected result word kind %0d byte 0x%02h last %0b",
                        $time, got.kind, got.payload_byte, got.last);
               fail_count++;
            end else begin
               word = expected_words.pop_front();
               if (got.kind !== word.kind) begin
                  $display("%0t: rsp_out_kind expected %0d actual %0d",
                           $time, word.kind, got.kind);
                  fail_count++;
               end
               if (got.payload_byte !== word.payload_byte) begin
                  $display("%0t: rsp_payload_byte expected 0x%02h actual 0x%02h",
                           $time, word.payload_byte, got.payload_byte);
                  fail_count++;
               end
               if (got.last !== word.last) begin
                  $display("%0t: rsp_last_in_message expected %0b actual %0b",
                           $time, word.last, got.last);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            live_state = deframe_next(live_state, req_data_byte, live_magic, emits, word);
            case (offered_row.mode)
               CHK_MODEL: begin
                  if (emits) expected_words.push_back(word);
               end
               CHK_WORD: begin
                  expected_words.push_back(offered_row.word);
               end
               default: begin
               end
            endcase
         end
      end
   end

   // Watchdog: end the run if nothing moves on any port for too long.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_psel && csr_penable && csr_pready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no handshake for %0d cycles, %0d words still expected",
                  $time, quiet_cycles, expected_words.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin : main_seq
      logic [31:0] phase_magic;
      logic [31:0] readback;

      // hold every input at a known value from time zero
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data_byte  = '0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      offered_row    = '0;
      gen_state      = '0;
      gen_magic      = '0;
      live_state     = '0;
      live_magic     = '0;
      idling_enabled = 1'b1;
      fail_count     = 0;
      quiet_cycles   = 0;
      rsp_stall_left = 0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed frames under the reset magic of zero:
      //   zero-length header -> one empty-message word
      //   two-byte payload    -> two payload words, last on the second
      //   all-ones header     -> magic mismatch, its length ignored
      directed_rows = '{
         stim_row(8'h00, CHK_SILENT), stim_row(8'h00, CHK_SILENT),
         stim_row(8'h00, CHK_SILENT), stim_row(8'h00, CHK_SILENT),
         stim_row(8'h00, CHK_SILENT), stim_row(8'h00, CHK_SILENT),
         stim_row(8'h00, CHK_SILENT),
         stim_row(8'h00, CHK_WORD, KIND_EMPTY, 8'h00, 1'b1),
         stim_row(8'h00, CHK_SILENT), stim_row(8'h00, CHK_SILENT),
         stim_row(8'h00, CHK_SILENT), stim_row(8'h00, CHK_SILENT),
         stim_row(8'h00, CHK_SILENT), stim_row(8'h00, CHK_SILENT),
         stim_row(8'h00, CHK_SILENT), stim_row(8'h02, CHK_SILENT),
         stim_row(8'hA5, CHK_MODEL),
         stim_row(8'hFF, CHK_MODEL),
         stim_row(8'hFF, CHK_SILENT), stim_row(8'hFF, CHK_SILENT),
         stim_row(8'hFF, CHK_SILENT), stim_row(8'hFF, CHK_SILENT),
         stim_row(8'hFF, CHK_SILENT), stim_row(8'hFF, CHK_SILENT),
         stim_row(8'hFF, CHK_SILENT),
         stim_row(8'hFF, CHK_WORD, KIND_MISMATCH, 8'h00, 1'b0)
      };
      foreach (directed_rows[i]) queue_row(directed_rows[i]);
      send_stream();

      // Random phases, each under its own magic; phases may end mid-frame,
      // so a new magic can land between header bytes.
      for (int p = 0; p < PHASES; p++) begin
         if (p == PHASES - 1) begin
            // no idling on either side in the final stretch
            @(posedge clock);
            idling_enabled = 1'b0;
         end
         wait_idle(SETTLE_CYCLES);
         case (p)
            0:       phase_magic = 32'hFFFF_FFFF;
            2:       phase_magic = 32'h0000_0000;
            default: phase_magic = $urandom;
         endcase
         csr_write(ADDR_MAGIC_WORD, phase_magic);
         // a write past the register map must not touch magic_word
         csr_write(ADDR_UNMAPPED, $urandom);
         csr_read(ADDR_MAGIC_WORD, readback);
         if (readback !== phase_magic) begin
            $display("%0t: magic_word readback expected 0x%08h actual 0x%08h",
                     $time, phase_magic, readback);
            fail_count++;
         end
         gen_magic = phase_magic;
         build_phase(ITEMS_PER_PHASE);
         send_stream();
      end

      wait_idle(TAIL_CYCLES);
      if (expected_words.size() != 0) begin
         $display("%0t: %0d expected result words never arrived",
                  $time, expected_words.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
